// ----- rtl/coordinate_delta_varint_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Coordinate delta decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_DELTA_VARINT_DECODER_MACROS_SVH
`define COORDINATE_DELTA_VARINT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CDVD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CDVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cdvd_pkg.sv -----
// ----------------------------------------------------------------------------
// Coordinate delta decoder package
// Widths, stream codes, phase and result kind types, result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdvd_pkg;

    localparam int SECTION_ID_BITS   = 16;
    localparam int RECORD_COUNT_BITS = 48;
    localparam int COORD_BITS        = 64;
    localparam int ACCUM_BITS        = 62;

    localparam logic [7:0] END_MARK   = 8'hff;
    localparam logic [7:0] NAME_END   = 8'h00;
    localparam logic [1:0] PFX_LONG   = 2'b11;
    localparam logic [1:0] PFX_SHORT  = 2'b10;
    localparam logic [2:0] LONG_BYTES = 3'd7;
    localparam logic [2:0] SHORT_BYTES = 3'd1;

    typedef enum logic [1:0] {
        PH_NAME_START  = 2'd0,
        PH_NAME_REST   = 2'd1,
        PH_DELTA_START = 2'd2,
        PH_DELTA_CONT  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_COORD = 2'd1,
        KIND_TRUNC = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic [7:0]                    name_char;
        logic [SECTION_ID_BITS-1:0]    section_id;
        logic [COORD_BITS-1:0]         coordinate;
        logic [RECORD_COUNT_BITS-1:0]  record_number;
    } t_result;

endpackage

// ----- rtl/coordinate_delta_varint_decoder.sv -----
// ----------------------------------------------------------------------------
// Coordinate delta varint decoder
// Decodes a sectioned, prefix-coded delta byte stream into name bytes,
// running coordinates and truncation markers.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the skid stage is empty; each accepted
// byte's result is registered, and the decode stage's 64-bit position adder
// sets the cycle time. A skid stage keeps input ready while a result waits.
// Reset: synchronous, active low; returns to the name-start phase with
// position, counters and the output and skid valid flags cleared.
`timescale 1ns / 1ps
`include "coordinate_delta_varint_decoder_macros.svh"

module coordinate_delta_varint_decoder (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [7:0]                               i_stream_byte,
    input  logic                                     i_last_byte,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [1:0]                               o_kind,
    output logic [7:0]                               o_name_char,
    output logic [cdvd_pkg::SECTION_ID_BITS-1:0]     o_section_id,
    output logic [cdvd_pkg::COORD_BITS-1:0]          o_coordinate,
    output logic [cdvd_pkg::RECORD_COUNT_BITS-1:0]   o_record_number
);

    // decoder state
    cdvd_pkg::t_phase                           r_phase, n_phase;
    logic [2:0]                                 r_left, n_left;
    logic [cdvd_pkg::ACCUM_BITS-1:0]            r_accum, n_accum;
    logic [cdvd_pkg::COORD_BITS-1:0]            r_pos, n_pos;
    logic [cdvd_pkg::SECTION_ID_BITS-1:0]       r_sec, n_sec;
    logic [cdvd_pkg::RECORD_COUNT_BITS-1:0]     r_rec, n_rec;
    logic                                       r_seen, n_seen;

    // output and skid stages
    logic                                       r_out_valid;
    cdvd_pkg::t_result                          r_out;
    logic                                       r_skid_valid;
    cdvd_pkg::t_result                          r_skid;

    logic                                       in_fire;
    logic                                       out_fire;
    logic                                       produce;
    logic                                       finish;
    cdvd_pkg::t_result                          n_result;

    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_accum  = r_accum;
        n_pos    = r_pos;
        n_sec    = r_sec;
        n_rec    = r_rec;
        n_seen   = r_seen;
        finish   = 1'b0;
        produce  = 1'b0;
        n_result.kind          = cdvd_pkg::KIND_NAME;
        n_result.name_char     = '0;
        n_result.section_id    = '0;
        n_result.coordinate    = '0;
        n_result.record_number = '0;

        unique case (r_phase)
            cdvd_pkg::PH_NAME_START, cdvd_pkg::PH_NAME_REST: begin
                if (r_phase == cdvd_pkg::PH_NAME_START) begin
                    if (r_seen && (r_sec != '1)) begin
                        n_sec = r_sec + 1'b1;
                    end
                    n_seen = 1'b1;
                    n_pos  = '0;
                end
                produce            = 1'b1;
                n_result.name_char = i_stream_byte;
                n_phase = (i_stream_byte == cdvd_pkg::NAME_END) ?
                          cdvd_pkg::PH_DELTA_START : cdvd_pkg::PH_NAME_REST;
            end
            cdvd_pkg::PH_DELTA_START: begin
                if (i_stream_byte == cdvd_pkg::END_MARK) begin
                    n_phase = cdvd_pkg::PH_NAME_START;
                    n_pos   = '0;
                end else if (i_stream_byte[7:6] == cdvd_pkg::PFX_LONG) begin
                    n_accum = {{(cdvd_pkg::ACCUM_BITS-6){1'b0}}, i_stream_byte[5:0]};
                    n_left  = cdvd_pkg::LONG_BYTES;
                    n_phase = cdvd_pkg::PH_DELTA_CONT;
                end else if (i_stream_byte[7:6] == cdvd_pkg::PFX_SHORT) begin
                    n_accum = {{(cdvd_pkg::ACCUM_BITS-6){1'b0}}, i_stream_byte[5:0]};
                    n_left  = cdvd_pkg::SHORT_BYTES;
                    n_phase = cdvd_pkg::PH_DELTA_CONT;
                end else begin
                    n_accum = {{(cdvd_pkg::ACCUM_BITS-7){1'b0}}, i_stream_byte[6:0]};
                    finish  = 1'b1;
                end
            end
            cdvd_pkg::PH_DELTA_CONT: begin
                // shift in one big-endian byte, top bits fall off
                n_accum = {r_accum[cdvd_pkg::ACCUM_BITS-9:0], i_stream_byte};
                n_left  = r_left - 3'd1;
                finish  = (n_left == 3'd0);
            end
            default: begin
                n_phase = cdvd_pkg::PH_NAME_START;
            end
        endcase

        if (finish) begin
            n_pos   = r_pos + {{(cdvd_pkg::COORD_BITS-cdvd_pkg::ACCUM_BITS){1'b0}}, n_accum};
            if (r_rec != '1) begin
                n_rec = r_rec + 1'b1;
            end
            n_accum       = '0;
            n_left        = '0;
            n_phase       = cdvd_pkg::PH_DELTA_START;
            produce       = 1'b1;
            n_result.kind = cdvd_pkg::KIND_COORD;
        end

        if (i_last_byte && (n_phase == cdvd_pkg::PH_DELTA_CONT)) begin
            produce       = 1'b1;
            n_result.kind = cdvd_pkg::KIND_TRUNC;
        end

        n_result.section_id    = n_sec;
        n_result.coordinate    = n_pos;
        n_result.record_number = n_rec;

        // end of stream: back to the reset state
        if (i_last_byte) begin
            n_phase = cdvd_pkg::PH_NAME_START;
            n_left  = '0;
            n_accum = '0;
            n_pos   = '0;
            n_sec   = '0;
            n_rec   = '0;
            n_seen  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cdvd_pkg::PH_NAME_START;
            r_left  <= '0;
            r_accum <= '0;
            r_pos   <= '0;
            r_sec   <= '0;
            r_rec   <= '0;
            r_seen  <= 1'b0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_accum <= n_accum;
            r_pos   <= n_pos;
            r_sec   <= n_sec;
            r_rec   <= n_rec;
            r_seen  <= n_seen;
        end
    end

    // output register with skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= in_fire && produce;
            end else begin
                r_out_valid  <= in_fire && produce;
            end
        end else if (in_fire && produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= n_result;
            end else begin
                r_out  <= n_result;
            end
        end else if (in_fire && produce) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_name_char     = r_out.name_char;
    assign o_section_id    = r_out.section_id;
    assign o_coordinate    = r_out.coordinate;
    assign o_record_number = r_out.record_number;

    `CDVD_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid holds a beat while output stage is empty")
    `CDVD_ASSERT_NOW(a_name_char_only_names, i_clk, i_rst_n, r_out_valid && (r_out.kind != cdvd_pkg::KIND_NAME), r_out.name_char == '0, "name byte on a non-name result")
    `CDVD_ASSERT_NEXT(a_last_resets, i_clk, i_rst_n, in_fire && i_last_byte, (r_phase == cdvd_pkg::PH_NAME_START) && (r_rec == '0) && (r_pos == '0) && !r_seen, "state not cleared after last byte")

endmodule
